// File: rtl/core/bmp24_pkg.sv
// Shared types and constants for the 24-bit BMP pixel unpacker.
// No dependencies.
package bmp24_pkg;

  // Header byte positions of the little-endian 32-bit words
  localparam logic [31:0] HDR_OFFSET_POS = 32'h0000_000A;
  localparam logic [31:0] HDR_WIDTH_POS  = 32'h0000_0012;
  localparam logic [31:0] HDR_HEIGHT_POS = 32'h0000_0016;
  localparam logic [31:0] HDR_END_POS    = 32'h0000_001A;
  localparam logic [31:0] POS_MAX        = 32'hFFFF_FFFF;
  localparam logic [15:0] SAT16          = 16'hFFFF;

  // Color byte expected next
  typedef enum logic [1:0] {
    PH_BLUE  = 2'd0,
    PH_GREEN = 2'd1,
    PH_RED   = 2'd2
  } phase_t;

  // One decoded pixel
  typedef struct packed {
    logic        end_of_image;
    logic        end_of_row;
    logic [15:0] row;
    logic [15:0] column;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } pix_res_t;

endpackage

// File: rtl/core/bmp24_parse.sv
// Header capture, pixel grouping and row/column tracking, one byte per step cycle.
// Depends on bmp24_pkg.
module bmp24_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,          // byte taken this cycle
  input  logic [7:0]         byte_value,
  input  logic               start_of_file,
  output logic               res_valid,
  output bmp24_pkg::pix_res_t res
);
  import bmp24_pkg::*;

  logic [31:0] pos_r, pos_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic [31:0] width_r, width_nxt;
  logic [31:0] height_r, height_nxt;
  logic [7:0]  blue_r, blue_nxt;
  logic [7:0]  green_r, green_nxt;
  phase_t      phase_r, phase_nxt;
  logic [31:0] col_r, col_nxt;
  logic [31:0] row_r, row_nxt;
  logic [1:0]  pad_r, pad_nxt;
  logic        done_r, done_nxt;

  // Values seen by this byte: a start mark clears everything first
  logic [31:0] e_pos, e_offset, e_width, e_height, e_col, e_row;
  phase_t      e_phase;
  logic [1:0]  e_pad;
  logic        e_done;
  logic [1:0]  lane;
  logic [31:0] lane_word;
  logic        last_col, last_row;

  always_comb begin
    e_pos    = start_of_file ? '0 : pos_r;
    e_offset = start_of_file ? '0 : offset_r;
    e_width  = start_of_file ? '0 : width_r;
    e_height = start_of_file ? '0 : height_r;
    e_col    = start_of_file ? '0 : col_r;
    e_row    = start_of_file ? '0 : row_r;
    e_phase  = start_of_file ? PH_BLUE : phase_r;
    e_pad    = start_of_file ? 2'd0 : pad_r;
    e_done   = start_of_file ? 1'b0 : done_r;

    // All three header words start at positions = 2 mod 4
    lane      = e_pos[1:0] - 2'd2;
    lane_word = {24'd0, byte_value} << {lane, 3'b000};

    last_col = (e_col == e_width - 32'd1);
    last_row = (e_row == e_height - 32'd1);

    pos_nxt    = (e_pos == POS_MAX) ? e_pos : e_pos + 32'd1;
    offset_nxt = e_offset;
    width_nxt  = e_width;
    height_nxt = e_height;
    blue_nxt   = blue_r;
    green_nxt  = green_r;
    phase_nxt  = e_phase;
    col_nxt    = e_col;
    row_nxt    = e_row;
    pad_nxt    = e_pad;
    done_nxt   = e_done;
    res_valid  = 1'b0;

    res.red          = byte_value;
    res.green        = green_r;
    res.blue         = blue_r;
    res.column       = (e_col > {16'd0, SAT16}) ? SAT16 : e_col[15:0];
    res.row          = (e_row > {16'd0, SAT16}) ? SAT16 : e_row[15:0];
    res.end_of_row   = last_col;
    res.end_of_image = last_col && last_row;

    priority if (e_pos < HDR_END_POS) begin
      if (e_pos >= HDR_OFFSET_POS && e_pos < HDR_OFFSET_POS + 32'd4)
        offset_nxt = e_offset | lane_word;
      if (e_pos >= HDR_WIDTH_POS && e_pos < HDR_WIDTH_POS + 32'd4)
        width_nxt = e_width | lane_word;
      if (e_pos >= HDR_HEIGHT_POS && e_pos < HDR_HEIGHT_POS + 32'd4)
        height_nxt = e_height | lane_word;
    end else if (e_pos < e_offset) begin
      // gap before pixel array
    end else if (e_done || e_width == '0 || e_height == '0) begin
      // nothing to emit
    end else if (e_pad != 2'd0) begin
      pad_nxt = e_pad - 2'd1;
    end else begin
      unique case (e_phase)
        PH_GREEN: begin
          green_nxt = byte_value;
          phase_nxt = PH_RED;
        end
        PH_RED: begin
          phase_nxt = PH_BLUE;
          res_valid = 1'b1;
          if (last_col) begin
            col_nxt = '0;
            if (last_row) begin
              done_nxt = 1'b1;
              pad_nxt  = 2'd0;
            end else begin
              pad_nxt = e_width[1:0];
              row_nxt = e_row + 32'd1;
            end
          end else begin
            col_nxt = e_col + 32'd1;
          end
        end
        default: begin
          blue_nxt  = byte_value;
          phase_nxt = PH_GREEN;
        end
      endcase
    end

    res_valid = res_valid && step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      offset_r <= '0;
      width_r  <= '0;
      height_r <= '0;
      phase_r  <= PH_BLUE;
      col_r    <= '0;
      row_r    <= '0;
      pad_r    <= '0;
      done_r   <= 1'b0;
    end else if (step) begin
      pos_r    <= pos_nxt;
      offset_r <= offset_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      phase_r  <= phase_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      pad_r    <= pad_nxt;
      done_r   <= done_nxt;
    end
  end

  // color holds are payload only
  always_ff @(posedge clk) begin
    if (step) begin
      blue_r  <= blue_nxt;
      green_r <= green_nxt;
    end
  end

endmodule

// File: rtl/core/bmp_24bit_pixel_unpacker.sv
// Top level of the 24-bit BMP pixel unpacker: byte stream in, pixel words out.
// Depends on bmp24_pkg and bmp24_parse.
//
// Usage:
//   in_*  : one file byte per word. in_tdata = byte_value, in_tuser =
//           start_of_file (set on byte 0 of each file; restarts parsing).
//   out_* : one word per decoded pixel, emitted on the red byte.
//           out_tlast marks the last pixel of a row, out_tuser the last
//           pixel of the image. Row 0 is the bottom row of the bitmap.
//   Header words (pixel offset, width, height) are picked up on the fly;
//   bytes before the pixel array, row padding and anything after the last
//   pixel produce no output word.
// Output: a pixel word is registered before it appears on out_*.
// Throughput: one byte per cycle while in_tready is high; the per-byte
//   decode is a single pass of counter updates and 32-bit compares between
//   the parse state registers and the output register.
// Stall: a two-entry output stage (output register plus skid register)
//   lets a byte be taken while a finished pixel waits; in_tready drops only
//   when both entries hold pixels, and is driven from a register.
// Reset: rst_n (synchronous, active low) empties the output stage and puts
//   the parser in the fresh-file state, so the first byte counts as byte 0.
module bmp_24bit_pixel_unpacker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic        in_tuser,   // [0] start_of_file
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [7:0] red, [15:8] green, [23:16] blue,
                                  // [39:24] column, [55:40] row
  output logic        out_tlast,  // end_of_row
  output logic        out_tuser   // [0] end_of_image
);
  import bmp24_pkg::*;

  logic     step;
  logic     res_valid;
  pix_res_t res;

  logic     out_valid_r, out_valid_nxt;
  pix_res_t out_data_r, out_data_nxt;
  logic     skid_valid_r, skid_valid_nxt;
  pix_res_t skid_data_r, skid_data_nxt;

  assign in_tready = !skid_valid_r;
  assign step      = in_tvalid && in_tready;

  bmp24_parse u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .byte_value    (in_tdata),
    .start_of_file (in_tuser),
    .res_valid     (res_valid),
    .res           (res)
  );

  // Output register with skid entry behind it
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_tready || !out_valid_r) begin
      if (skid_valid_r) begin
        // no byte is taken while the skid entry is full
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res_valid;
        out_data_nxt  = res;
      end
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data_r.row, out_data_r.column, out_data_r.blue,
                       out_data_r.green, out_data_r.red};
  assign out_tlast  = out_data_r.end_of_row;
  assign out_tuser  = out_data_r.end_of_image;

endmodule
